/* rtl/gha_pkg.sv */
package gha_pkg;

  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int SER_W = 32;
  localparam int OBJ_W = 32;
  localparam int ST_W  = 3;
  localparam int CNT_W = 11;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESOLVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_STALE    = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_NULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_MISMATCH = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic alloc_fin;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_serial;
  } sts_t;

endpackage

/* rtl/gha_ram.sv */
module gha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gha_dp.sv */
module gha_dp #(
  parameter int SLOTS     = 1024,
  parameter int REF_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gha_pkg::cmd_t               cmd_i,
  output gha_pkg::sts_t               sts_o,
  input  logic [gha_pkg::OP_W-1:0]    operation_i,
  input  logic [gha_pkg::IDX_W-1:0]   slot_index_i,
  input  logic [gha_pkg::SER_W-1:0]   serial_tag_i,
  input  logic [gha_pkg::OBJ_W-1:0]   object_ref_i,
  output logic [gha_pkg::ST_W-1:0]    status_o,
  output logic [gha_pkg::IDX_W-1:0]   out_index_o,
  output logic [gha_pkg::SER_W-1:0]   out_serial_o,
  output logic [gha_pkg::OBJ_W-1:0]   out_object_o,
  output logic [gha_pkg::CNT_W-1:0]   live_count_o
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = (REF_WIDTH < gha_pkg::OBJ_W) ? REF_WIDTH : gha_pkg::OBJ_W;

  // Captured word.
  logic [gha_pkg::OP_W-1:0]  op_q;
  logic [gha_pkg::IDX_W-1:0] idx_q;
  logic [gha_pkg::SER_W-1:0] ser_q;
  logic [RW-1:0]             obj_q;
  logic [AW-1:0]             slot_q, slot_d;

  // Allocation counters.
  logic [CW-1:0] free_top_q, free_top_d;
  logic [CW-1:0] high_water_q, high_water_d;
  logic [CW-1:0] total_q, total_d;

  // Result waiting for the output register, and the output register itself.
  logic [gha_pkg::ST_W-1:0]  res_st_q, res_st_d;
  logic [gha_pkg::IDX_W-1:0] res_idx_q, res_idx_d;
  logic [gha_pkg::SER_W-1:0] res_ser_q, res_ser_d;
  logic [gha_pkg::OBJ_W-1:0] res_obj_q, res_obj_d;
  logic [gha_pkg::CNT_W-1:0] res_live_q;
  logic                      res_load;

  logic [gha_pkg::ST_W-1:0]  out_st_q;
  logic [gha_pkg::IDX_W-1:0] out_idx_q;
  logic [gha_pkg::SER_W-1:0] out_ser_q;
  logic [gha_pkg::OBJ_W-1:0] out_obj_q;
  logic [gha_pkg::CNT_W-1:0] out_live_q;

  // Memory ports.
  logic                      obj_we, ser_we, ser_re, stk_we;
  logic [AW-1:0]             obj_waddr, ser_waddr, ser_raddr;
  logic [RW-1:0]             obj_wdata, obj_rdata;
  logic [gha_pkg::SER_W-1:0] ser_wdata, ser_rdata, ser_inc;
  logic [AW-1:0]             stk_rdata;

  logic [AW-1:0] in_addr, idx_addr, hw_addr, stk_raddr;
  logic          in_range, obj_null, need_serial;

  assign in_addr   = AW'(slot_index_i);
  assign idx_addr  = AW'(idx_q);
  assign hw_addr   = AW'(high_water_q);
  assign stk_raddr = AW'(free_top_q - CW'(1));
  assign in_range  = 32'(idx_q) < 32'(high_water_q);
  assign obj_null  = (obj_q == '0);

  // Serial advance wraps and skips zero.
  assign ser_inc = (ser_rdata + 32'd1 == '0) ? 32'd1 : ser_rdata + 32'd1;

  assign ser_re    = cmd_i.capture | (cmd_i.eval & need_serial);
  assign ser_raddr = cmd_i.capture ? in_addr : stk_rdata;

  always_comb begin
    res_st_d     = gha_pkg::ST_STALE;
    res_idx_d    = idx_q;
    res_ser_d    = '0;
    res_obj_d    = '0;
    need_serial  = 1'b0;
    obj_we       = 1'b0;
    obj_waddr    = idx_addr;
    obj_wdata    = obj_q;
    ser_we       = 1'b0;
    ser_waddr    = idx_addr;
    ser_wdata    = ser_inc;
    stk_we       = 1'b0;
    slot_d       = slot_q;
    free_top_d   = free_top_q;
    high_water_d = high_water_q;
    total_d      = total_q;

    if (cmd_i.eval) begin
      case (op_q)
        gha_pkg::OP_ALLOC: begin
          res_idx_d = '0;
          if (obj_null) begin
            res_st_d = gha_pkg::ST_NULL;
          end else if (free_top_q != '0) begin
            // Reused slot: its serial is read in the next cycle.
            need_serial = 1'b1;
            slot_d      = stk_rdata;
          end else if (high_water_q < CW'(SLOTS)) begin
            res_st_d     = gha_pkg::ST_OK;
            res_idx_d    = gha_pkg::IDX_W'(high_water_q);
            res_ser_d    = 32'd1;
            ser_we       = 1'b1;
            ser_waddr    = hw_addr;
            ser_wdata    = 32'd1;
            obj_we       = 1'b1;
            obj_waddr    = hw_addr;
            high_water_d = high_water_q + CW'(1);
            total_d      = total_q + CW'(1);
          end else begin
            res_st_d = gha_pkg::ST_FULL;
          end
        end
        gha_pkg::OP_FREE: begin
          if (!in_range) begin
            res_st_d = gha_pkg::ST_STALE;
          end else if (obj_null) begin
            res_st_d = gha_pkg::ST_NULL;
          end else if (ser_rdata != ser_q || obj_rdata != obj_q) begin
            res_st_d = gha_pkg::ST_MISMATCH;
          end else begin
            res_st_d  = gha_pkg::ST_OK;
            obj_we    = 1'b1;
            obj_wdata = '0;
            ser_we    = 1'b1;
            if (free_top_q < CW'(SLOTS)) begin
              stk_we     = 1'b1;
              free_top_d = free_top_q + CW'(1);
            end
            if (total_q != '0) begin
              total_d = total_q - CW'(1);
            end
          end
        end
        gha_pkg::OP_RESOLVE: begin
          if (ser_q == '0 || !in_range || ser_rdata != ser_q || obj_rdata == '0) begin
            res_st_d = gha_pkg::ST_STALE;
          end else begin
            res_st_d  = gha_pkg::ST_OK;
            res_obj_d = gha_pkg::OBJ_W'(obj_rdata);
          end
        end
        default: begin
          res_st_d = gha_pkg::ST_STALE;
        end
      endcase
    end else if (cmd_i.alloc_fin) begin
      res_st_d   = gha_pkg::ST_OK;
      res_idx_d  = gha_pkg::IDX_W'(slot_q);
      res_ser_d  = ser_rdata;
      obj_we     = 1'b1;
      obj_waddr  = slot_q;
      free_top_d = free_top_q - CW'(1);
      total_d    = total_q + CW'(1);
    end
  end

  assign res_load          = (cmd_i.eval & ~need_serial) | cmd_i.alloc_fin;
  assign sts_o.need_serial = need_serial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q   <= '0;
      high_water_q <= '0;
      total_q      <= '0;
    end else begin
      free_top_q   <= free_top_d;
      high_water_q <= high_water_d;
      total_q      <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      idx_q <= slot_index_i;
      ser_q <= serial_tag_i;
      obj_q <= object_ref_i[RW-1:0];
    end
    slot_q <= slot_d;
    if (res_load) begin
      res_st_q   <= res_st_d;
      res_idx_q  <= res_idx_d;
      res_ser_q  <= res_ser_d;
      res_obj_q  <= res_obj_d;
      res_live_q <= gha_pkg::CNT_W'(total_d);
    end
    if (cmd_i.load_out) begin
      out_st_q   <= res_st_q;
      out_idx_q  <= res_idx_q;
      out_ser_q  <= res_ser_q;
      out_obj_q  <= res_obj_q;
      out_live_q <= res_live_q;
    end
  end

  assign status_o     = out_st_q;
  assign out_index_o  = out_idx_q;
  assign out_serial_o = out_ser_q;
  assign out_object_o = out_obj_q;
  assign live_count_o = out_live_q;

  gha_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_obj_ram (
    .clk_i   (clk_i),
    .we_i    (obj_we),
    .waddr_i (obj_waddr),
    .wdata_i (obj_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (in_addr),
    .rdata_o (obj_rdata)
  );

  gha_ram #(.WIDTH(gha_pkg::SER_W), .DEPTH(SLOTS)) u_ser_ram (
    .clk_i   (clk_i),
    .we_i    (ser_we),
    .waddr_i (ser_waddr),
    .wdata_i (ser_wdata),
    .re_i    (ser_re),
    .raddr_i (ser_raddr),
    .rdata_o (ser_rdata)
  );

  gha_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (AW'(free_top_q)),
    .wdata_i (idx_addr),
    .re_i    (cmd_i.capture),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

endmodule

/* rtl/gha_ctrl.sv */
module gha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gha_pkg::cmd_t cmd_o,
  input  gha_pkg::sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_ALLOC
  } state_e;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;
  logic   out_valid_q, out_valid_d;
  logic   res_to_out, finish;

  assign res_to_out = res_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = (state_q == S_IDLE) & (~res_valid_q | res_to_out);
  assign finish     = ((state_q == S_EVAL) & ~sts_i.need_serial) | (state_q == S_ALLOC);

  assign cmd_o.capture   = in_valid_i & in_ready_o;
  assign cmd_o.eval      = (state_q == S_EVAL);
  assign cmd_o.alloc_fin = (state_q == S_ALLOC);
  assign cmd_o.load_out  = res_to_out;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = sts_i.need_serial ? S_ALLOC : S_IDLE;
      end
      S_ALLOC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A finished result always finds the hold register empty, since a word is
  // only taken once the previous result has moved on.
  assign res_valid_d = finish | (res_valid_q & ~res_to_out);
  assign out_valid_d = res_to_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/generational_handle_allocator.sv */
// An accepted word is captured, then evaluated; allocate from the free stack
// adds a step that reads the reused slot's serial before the result is made.
// The result passes through a hold register to the output register. A new
// word is taken only once the last one is finished and its result moved on.
// Reset clears the controller, the stack pointer, high-water mark and live
// count at once; slot memories are not cleared and no clearing pass is needed.
module generational_handle_allocator #(
  parameter int SLOTS     = 1024,
  parameter int REF_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [gha_pkg::OP_W-1:0]  operation_i,
  input  logic [gha_pkg::IDX_W-1:0] slot_index_i,
  input  logic [gha_pkg::SER_W-1:0] serial_tag_i,
  input  logic [gha_pkg::OBJ_W-1:0] object_ref_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [gha_pkg::ST_W-1:0]  status_o,
  output logic [gha_pkg::IDX_W-1:0] out_index_o,
  output logic [gha_pkg::SER_W-1:0] out_serial_o,
  output logic [gha_pkg::OBJ_W-1:0] out_object_o,
  output logic [gha_pkg::CNT_W-1:0] live_count_o
);

  gha_pkg::cmd_t cmd;
  gha_pkg::sts_t sts;

  gha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gha_dp #(
    .SLOTS     (SLOTS),
    .REF_WIDTH (REF_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (operation_i),
    .slot_index_i (slot_index_i),
    .serial_tag_i (serial_tag_i),
    .object_ref_i (object_ref_i),
    .status_o     (status_o),
    .out_index_o  (out_index_o),
    .out_serial_o (out_serial_o),
    .out_object_o (out_object_o),
    .live_count_o (live_count_o)
  );

endmodule

/* rtl/gha_checker.sv */
module gha_checker #(
  parameter int SLOTS = 1024
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [gha_pkg::ST_W-1:0]  status_o,
  input logic [gha_pkg::IDX_W-1:0] out_index_o,
  input logic [gha_pkg::SER_W-1:0] out_serial_o,
  input logic [gha_pkg::OBJ_W-1:0] out_object_o,
  input logic [gha_pkg::CNT_W-1:0] live_count_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(out_index_o) && $stable(out_serial_o) && $stable(out_object_o) &&
      $stable(live_count_o))
    else $error("result word changed while stalled");

  // One word is worked on at a time, so the input side closes after a take.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted in back-to-back cycles");

  // A failed operation never hands out a serial or an object.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != gha_pkg::ST_OK |-> out_serial_o == '0 && out_object_o == '0)
    else $error("failed operation carries a serial or an object");

  // The live count never exceeds the table capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(live_count_o) <= SLOTS)
    else $error("live count above capacity");

endmodule

bind generational_handle_allocator gha_checker #(.SLOTS(SLOTS)) u_gha_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .out_index_o  (out_index_o),
  .out_serial_o (out_serial_o),
  .out_object_o (out_object_o),
  .live_count_o (live_count_o)
);
